FILE: rtl/mpma_pkg.sv
// Shared constants, codes and result type of the multi-pattern match automaton.
`default_nettype none
package mpma_pkg;

  localparam int MAX_NODES_DEF     = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam logic [7:0] BASE_CHAR_RESET = 8'd97;

  localparam int NODE_OUT_W  = 10;
  localparam int COUNT_W     = 16;
  localparam int NCOUNT_W    = 11;
  localparam int STATUS_W    = 3;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_BUILD   = 2'd1;
  localparam logic [1:0] ACT_NEXT    = 2'd2;
  localparam logic [1:0] ACT_INSPECT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADSYM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PHASE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADNODE = 3'd4;

  // first member sits in the highest bits, so node_out lands at bit 0
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [NCOUNT_W-1:0]   node_count;
    logic [NODE_OUT_W-1:0] fail_out;
    logic [COUNT_W-1:0]    match_total;
    logic [NODE_OUT_W-1:0] node_out;
  } res_t;

  localparam int RES_W  = $bits(res_t);
  localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mpma_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mpma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mpma_out.sv
// Output register holding one result until the downstream side takes it.
`default_nettype none
module mpma_out
  import mpma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire res_t din,
  input  wire logic ready,
  output logic      valid,
  output res_t      dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/multi_pattern_match_automaton_unit.sv
// Top level: Aho-Corasick automaton sequencer over goto, failure, count and queue RAMs.
//
// Channel   Dir  Signals                         Contents (low bit up)
// s_axis    in   tdata[23:0] tuser[1:0] tlast    tdata: symbol, node_index; tuser: action;
//                                                tlast: pattern_end
// m_axis    out  tdata[55:0]                     node_out, match_total, fail_out,
//                                                node_count, status
// cfg       in   cfg_wen cfg_wdata[7:0]          base_char
//
// Build: the goto RAM port serves one read of a node row and one of its failure row
//   per edge, over the root row first and then over each trie node in queue order.
// Reset: a clearing pass over every goto entry zeroes the goto, failure and count
//   RAMs; no item is accepted meanwhile, cfg writes are taken as ever.
// Stalls: a held result blocks the next one, and no new item is taken until that one loads.
`default_nettype none
module multi_pattern_match_automaton_unit
  import mpma_pkg::*;
#(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [23:0]            s_axis_tdata,  // [7:0] symbol, [17:8] node_index
  input  wire logic [1:0]             s_axis_tuser,  // [1:0] action
  input  wire logic                   s_axis_tlast,  // pattern_end
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,  // node_out, match_total, fail_out,
                                                     // node_count, status
  input  wire logic                   cfg_wen,
  input  wire logic [7:0]             cfg_wdata
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int GA    = $clog2(DEPTH);
  localparam int SW    = $clog2(ALPHABET_SIZE);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_A2    = 5'd2;
  localparam logic [4:0] S_A3    = 5'd3;
  localparam logic [4:0] S_N2    = 5'd4;
  localparam logic [4:0] S_N3    = 5'd5;
  localparam logic [4:0] S_B_RC  = 5'd6;
  localparam logic [4:0] S_B_POP = 5'd7;
  localparam logic [4:0] S_B_V   = 5'd8;
  localparam logic [4:0] S_B_F   = 5'd9;
  localparam logic [4:0] S_B_C   = 5'd10;
  localparam logic [4:0] S_B_RG  = 5'd11;
  localparam logic [4:0] S_B_WR  = 5'd12;
  localparam logic [4:0] S_OUT   = 5'd13;

  logic [4:0]    state, state_next;
  logic [7:0]    base_char;
  logic [GA-1:0] clr;
  logic [NW:0]   nodes_used;
  logic [NW-1:0] cursor;
  logic          built;
  logic          pend_r;
  logic [NW-1:0] node_r;
  logic [NW-1:0] x_r;
  logic [GA-1:0] ga, vbase, fbase;
  logic [SW-1:0] idx;
  logic [NW:0]   head, tail;
  logic [COUNT_W-1:0] cv_r;
  res_t          res_r;

  // memory ports
  logic          g_we;
  logic [GA-1:0] g_waddr, g_raddr;
  logic [NW-1:0] g_wdata, g_rdata;
  logic          f_we;
  logic [NW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
  logic          c_we;
  logic [NW-1:0] c_waddr, c_raddr;
  logic [COUNT_W-1:0] c_wdata, c_rdata;
  logic          q_we;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  // input decode
  logic [1:0]    act;
  logic [7:0]    sym_raw;
  logic [9:0]    nidx;
  logic [8:0]    diff;
  logic          sym_bad, node_bad, accept, out_free, out_load;
  logic [SW-1:0] sym_idx;
  logic [NW-1:0] nidx_n;
  logic [GA-1:0] cur_addr, nxt_addr;
  logic          idx_last, nxt_zero, full;
  logic [NW-1:0] nxt_node;
  logic [COUNT_W-1:0] add_total;
  logic [STATUS_W-1:0] in_status;

  assign act      = s_axis_tuser;
  assign sym_raw  = s_axis_tdata[7:0];
  assign nidx     = s_axis_tdata[17:8];
  assign diff     = {1'b0, sym_raw} - {1'b0, base_char};
  assign sym_bad  = diff[8] || (9'(diff[7:0]) >= 9'(ALPHABET_SIZE));
  assign sym_idx  = SW'(diff[7:0]);
  assign node_bad = 17'(nidx) >= 17'(nodes_used);
  assign nidx_n   = NW'(nidx);
  assign cur_addr = GA'(cursor) * GA'(ALPHABET_SIZE) + GA'(sym_idx);
  assign nxt_addr = GA'(nidx_n) * GA'(ALPHABET_SIZE) + GA'(sym_idx);
  assign idx_last = idx == SW'(ALPHABET_SIZE - 1);
  assign nxt_zero = g_rdata == '0;
  assign full     = nodes_used >= (NW+1)'(MAX_NODES);
  assign nxt_node = nxt_zero ? NW'(nodes_used) : g_rdata;
  assign add_total = pend_r ? sat_add(c_rdata, COUNT_W'(1)) : c_rdata;

  assign s_axis_tready = state == S_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = state == S_OUT && out_free;

  // status of an incoming transaction: phase first, then node, then symbol
  always_comb begin
    priority if (act == ACT_ADD && built)       in_status = ST_PHASE;
    else if (act == ACT_ADD && sym_bad)         in_status = ST_BADSYM;
    else if (act == ACT_BUILD && built)         in_status = ST_PHASE;
    else if (act == ACT_NEXT && !built)         in_status = ST_PHASE;
    else if (act == ACT_NEXT && node_bad)       in_status = ST_BADNODE;
    else if (act == ACT_NEXT && sym_bad)        in_status = ST_BADSYM;
    else if (act == ACT_INSPECT && node_bad)    in_status = ST_BADNODE;
    else                                        in_status = ST_OK;
  end

  // memory port steering and next state
  always_comb begin
    state_next = state;
    g_we = 1'b0; g_waddr = ga; g_wdata = '0; g_raddr = '0;
    f_we = 1'b0; f_waddr = x_r; f_wdata = '0; f_raddr = '0;
    c_we = 1'b0; c_waddr = node_r; c_wdata = '0; c_raddr = '0;
    q_we = 1'b0; q_waddr = NW'(tail); q_wdata = x_r; q_raddr = NW'(head);
    unique case (state)
      S_CLEAR: begin
        g_we = 1'b1; g_waddr = clr;
        f_we = (GA+1)'(clr) < (GA+1)'(MAX_NODES); f_waddr = NW'(clr);
        c_we = f_we; c_waddr = NW'(clr);
        if (clr == GA'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_OUT;
          unique case (act)
            ACT_ADD: begin
              if (!built && !sym_bad) begin
                g_raddr = cur_addr;
                state_next = S_A2;
              end
            end
            ACT_BUILD: begin
              if (!built) begin
                g_raddr = '0;
                state_next = S_B_RC;
              end
            end
            ACT_NEXT: begin
              if (built && !node_bad && !sym_bad) begin
                g_raddr = nxt_addr;
                state_next = S_N2;
              end
            end
            ACT_INSPECT: begin
              if (!node_bad) begin
                f_raddr = nidx_n; c_raddr = nidx_n;
                state_next = S_N3;
              end
            end
          endcase
        end
      end
      S_A2: begin
        state_next = S_OUT;
        if (!(nxt_zero && full)) begin
          g_we = nxt_zero; g_wdata = nxt_node;
          c_raddr = nxt_node;
          state_next = S_A3;
        end
      end
      S_A3: begin
        c_we = pend_r; c_wdata = add_total;
        state_next = S_OUT;
      end
      S_N2: begin
        f_raddr = g_rdata; c_raddr = g_rdata;
        state_next = S_N3;
      end
      S_N3: begin
        state_next = S_OUT;
      end
      S_B_RC: begin
        q_we = !nxt_zero && tail < (NW+1)'(MAX_NODES); q_wdata = g_rdata;
        g_raddr = GA'(idx) + GA'(1);
        if (idx_last) begin
          state_next = S_B_POP;
        end
      end
      S_B_POP: begin
        state_next = (head == tail) ? S_OUT : S_B_V;
      end
      S_B_V: begin
        f_raddr = q_rdata; c_raddr = q_rdata;
        state_next = S_B_F;
      end
      S_B_F: begin
        c_raddr = f_rdata;
        state_next = S_B_C;
      end
      S_B_C: begin
        c_we = 1'b1; c_wdata = sat_add(cv_r, c_rdata);
        g_raddr = vbase;
        state_next = S_B_RG;
      end
      S_B_RG: begin
        g_raddr = fbase + GA'(idx);
        state_next = S_B_WR;
      end
      S_B_WR: begin
        // child present: link it and queue it; edge missing: borrow the failure row
        f_we = x_r != '0; f_wdata = g_rdata;
        q_we = x_r != '0 && tail < (NW+1)'(MAX_NODES);
        g_we = x_r == '0; g_waddr = vbase + GA'(idx); g_wdata = g_rdata;
        g_raddr = vbase + GA'(idx) + GA'(1);
        state_next = idx_last ? S_B_POP : S_B_RG;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      base_char  <= BASE_CHAR_RESET;
      clr        <= '0;
      nodes_used <= (NW+1)'(1);
      cursor     <= '0;
      built      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        base_char <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: clr <= clr + GA'(1);
        S_A2: begin
          if (nxt_zero && !full) begin
            nodes_used <= nodes_used + (NW+1)'(1);
          end
        end
        S_A3: cursor <= pend_r ? '0 : node_r;
        S_B_POP: begin
          if (head == tail) begin
            built  <= 1'b1;
            cursor <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_r <= '{status: in_status, node_count: NCOUNT_W'(nodes_used), default: '0};
        pend_r <= s_axis_tlast;
        ga     <= cur_addr;
        node_r <= nidx_n;
        idx    <= '0;
        head   <= '0;
        tail   <= '0;
      end
      S_A2: begin
        node_r <= nxt_node;
        if (nxt_zero && full) begin
          res_r.status <= ST_FULL;
        end
      end
      S_A3: begin
        res_r <= '{status: ST_OK, node_count: NCOUNT_W'(nodes_used),
                   fail_out: '0, match_total: add_total,
                   node_out: NODE_OUT_W'(node_r)};
      end
      S_N2: node_r <= g_rdata;
      S_N3: begin
        res_r.node_out    <= NODE_OUT_W'(node_r);
        res_r.match_total <= c_rdata;
        res_r.fail_out    <= NODE_OUT_W'(f_rdata);
      end
      S_B_RC: begin
        if (q_we) begin
          tail <= tail + (NW+1)'(1);
        end
        idx <= idx + SW'(1);
      end
      S_B_POP: head <= (head == tail) ? head : head + (NW+1)'(1);
      S_B_V: begin
        node_r <= q_rdata;
        vbase  <= GA'(q_rdata) * GA'(ALPHABET_SIZE);
      end
      S_B_F: begin
        fbase <= GA'(f_rdata) * GA'(ALPHABET_SIZE);
        cv_r  <= c_rdata;
      end
      S_B_C: idx <= '0;
      S_B_RG: x_r <= g_rdata;
      S_B_WR: begin
        if (q_we) begin
          tail <= tail + (NW+1)'(1);
        end
        idx <= idx + SW'(1);
      end
      default: ;
    endcase
  end

  mpma_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  mpma_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  mpma_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_count (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  mpma_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  res_t out_res;

  mpma_out u_out (
    .clk(clk), .rst(rst), .load(out_load), .din(res_r),
    .ready(m_axis_tready), .valid(m_axis_tvalid), .dout(out_res)
  );

  assign m_axis_tdata = TDATA_OUT_W'(out_res);

`ifndef SYNTHESIS
  a_nodes_range: assert property (@(posedge clk) disable iff (rst)
    nodes_used >= (NW+1)'(1) && nodes_used <= (NW+1)'(MAX_NODES))
    else $error("node count out of range");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_A2 && g_we) |=> nodes_used == $past(nodes_used) + (NW+1)'(1))
    else $error("new trie edge without node allocation");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_POP) |-> head <= tail)
    else $error("visit queue read past its tail");

  a_built_once: assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> $past(state) == S_B_POP)
    else $error("links marked built outside the build pass");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_multi_pattern_match_automaton_unit.sv
// Self-checking testbench for the multi-pattern match automaton unit.
`default_nettype none

module tb_multi_pattern_match_automaton_unit;
  import mpma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = MAX_NODES_DEF;
  localparam int ALPH  = ALPHABET_SIZE_DEF;
  localparam int SETTLE_CYCLES = 20;

  // Automaton predictor plus the queue of results it still owes the DUT.
  class automaton_scoreboard;
    int          goto_next [NODES*ALPH];
    int          fail_link [NODES];
    int          pat_count [NODES];
    int          visit [NODES];
    int          nodes_used;
    int          cursor;
    bit          built;
    logic [7:0]  base;
    res_t        pending_results[$];
    int          errors;

    function new();
      foreach (goto_next[i]) goto_next[i] = 0;
      foreach (fail_link[i]) fail_link[i] = 0;
      foreach (pat_count[i]) pat_count[i] = 0;
      nodes_used = 1;
      cursor     = 0;
      built      = 0;
      base       = BASE_CHAR_RESET;
      errors     = 0;
    endfunction

    function int clamp16(int v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function void link_automaton();
      int head;
      int tail;
      int v;
      int f;
      int x;
      head = 0;
      tail = 0;
      for (int i = 0; i < ALPH; i++) begin
        x = goto_next[i];
        if (x != 0 && tail < NODES) begin
          fail_link[x] = 0;
          visit[tail++] = x;
        end
      end
      while (head < tail) begin
        v = visit[head++];
        f = fail_link[v];
        pat_count[v] = clamp16(pat_count[v] + pat_count[f]);
        for (int i = 0; i < ALPH; i++) begin
          x = goto_next[v*ALPH + i];
          if (x != 0) begin
            fail_link[x] = goto_next[f*ALPH + i];
            if (tail < NODES) visit[tail++] = x;
          end else begin
            goto_next[v*ALPH + i] = goto_next[f*ALPH + i];
          end
        end
      end
    endfunction

    // Predict the one result of an accepted transaction and queue it.
    function void note_item(logic [1:0] act, logic [7:0] sym, logic pend, logic [9:0] node);
      res_t        r;
      int          idx;
      int          nxt;
      logic [2:0]  st;
      nxt = 0;
      st  = ST_OK;
      idx = int'(sym) - int'(base);
      if (idx < 0 || idx >= ALPH) idx = -1;
      case (act)
        ACT_ADD: begin
          if (built) st = ST_PHASE;
          else if (idx < 0) st = ST_BADSYM;
          else begin
            nxt = goto_next[cursor*ALPH + idx];
            if (nxt == 0) begin
              if (nodes_used >= NODES) st = ST_FULL;
              else begin
                nxt = nodes_used++;
                goto_next[cursor*ALPH + idx] = nxt;
              end
            end
            if (st == ST_OK) begin
              if (pend) begin
                pat_count[nxt] = clamp16(pat_count[nxt] + 1);
                cursor = 0;
              end else begin
                cursor = nxt;
              end
            end
          end
        end
        ACT_BUILD: begin
          if (built) st = ST_PHASE;
          else begin
            link_automaton();
            built  = 1;
            cursor = 0;
          end
        end
        ACT_NEXT: begin
          if (!built) st = ST_PHASE;
          else if (int'(node) >= nodes_used) st = ST_BADNODE;
          else if (idx < 0) st = ST_BADSYM;
          else nxt = goto_next[int'(node)*ALPH + idx];
        end
        default: begin
          if (int'(node) >= nodes_used) st = ST_BADNODE;
          else nxt = int'(node);
        end
      endcase
      r = '0;
      r.status     = st;
      r.node_count = nodes_used[NCOUNT_W-1:0];
      if (st == ST_OK) begin
        r.node_out    = nxt[NODE_OUT_W-1:0];
        r.match_total = pat_count[nxt][COUNT_W-1:0];
        r.fail_out    = fail_link[nxt][NODE_OUT_W-1:0];
      end
      pending_results = {pending_results, r};
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [TDATA_OUT_W-1:0] data);
      res_t got;
      res_t want;
      got = res_t'(data[RES_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tdata %h", data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("node_out",    want.node_out,    got.node_out);
      compare_field("match_total", want.match_total, got.match_total);
      compare_field("fail_out",    want.fail_out,    got.fail_out);
      compare_field("node_count",  want.node_count,  got.node_count);
      compare_field("status",      want.status,      got.status);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata;   // [7:0] symbol, [17:8] node_index
  logic [1:0]             s_axis_tuser;   // [1:0] action
  logic                   s_axis_tlast;   // pattern_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;   // node_out, match_total, fail_out,
                                          // node_count, status
  logic                   cfg_wen;
  logic [7:0]             cfg_wdata;

  automaton_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;

  multi_pattern_match_automaton_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: decide ready at each falling edge, stall at the current rate.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Check every result transaction at the rising edge it is taken.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Hard stop well beyond the slowest legal run (reset clear, build, stalled traffic).
  initial begin
    #100_000_000;
    $display("** multi_pattern_match_automaton_unit: FAILED **");
    $finish;
  end

  // Offer one item; hold it until the DUT takes it. Called at a falling edge.
  task automatic send_item(logic [1:0] act, logic [7:0] sym, logic pend, logic [9:0] node);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tuser  = act;
    s_axis_tdata  = {6'd0, node, sym};
    s_axis_tlast  = pend;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(act, sym, pend, node);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back, then let
  // the DUT settle before touching the register.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(logic [7:0] value);
    drain_results();
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen   = 1'b0;
    sb.base   = value;
  endtask

  // Symbol for add/next: mostly in the alphabet, sometimes any code.
  function automatic logic [7:0] pick_symbol(int span);
    if ($urandom_range(0, 99) < 10) return 8'($urandom_range(0, 255));
    return 8'(int'(sb.base) + $urandom_range(0, span - 1));
  endfunction

  initial begin
    int len;
    logic [7:0] sym;
    sb = new();
    tx_idle_pct   = 34;
    rx_idle_pct   = 67;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_ADD;
    s_axis_tlast  = 1'b0;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, before build: phase, node and symbol errors, then a few patterns.
    write_base(8'd97);
    send_item(ACT_INSPECT, 8'd0, 1'b0, 10'd0);
    send_item(ACT_INSPECT, 8'd0, 1'b0, 10'd1);
    send_item(ACT_INSPECT, 8'hff, 1'b1, 10'd1023);
    send_item(ACT_NEXT, 8'd97, 1'b0, 10'd0);
    send_item(ACT_ADD, 8'd96, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd123, 1'b0, 10'd0);
    send_item(ACT_ADD, 8'd0, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd255, 1'b0, 10'd0);
    send_item(ACT_ADD, 8'd97, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd122, 1'b0, 10'd0);
    send_item(ACT_ADD, 8'd122, 1'b1, 10'd0);
    send_item(ACT_INSPECT, 8'd0, 1'b0, 10'd2);
    // Lowest and highest base: index shifts to the raw codes at each end.
    write_base(8'd0);
    send_item(ACT_ADD, 8'd0, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd25, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd26, 1'b1, 10'd0);
    write_base(8'd255);
    send_item(ACT_ADD, 8'd255, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd254, 1'b0, 10'd0);
    write_base(8'd97);

    // Random patterns, mostly over a narrow alphabet so prefixes are shared, with noise.
    for (int p = 0; p < 60; p++) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 8)
          send_item(ACT_INSPECT, 8'($urandom), 1'($urandom),
                    10'($urandom_range(0, sb.nodes_used + 3)));
        sym = pick_symbol((p % 4 == 0) ? ALPH : 5);
        send_item(ACT_ADD, sym, (k == len - 1), 10'($urandom));
      end
    end

    // Repeat a short pattern so counts pile up and carry through failure links.
    for (int n = 0; n < 4; n++) send_item(ACT_ADD, 8'd98, 1'b1, 10'd0);
    send_item(ACT_ADD, 8'd97, 1'b0, 10'd0);
    send_item(ACT_ADD, 8'd98, 1'b1, 10'd0);

    // Wait for every result, then swap idle rates.
    drain_results();
    tx_idle_pct = 67;
    rx_idle_pct = 34;

    // Build, then confirm that add and build are refused afterward.
    send_item(ACT_BUILD, 8'd0, 1'b0, 10'd0);
    send_item(ACT_BUILD, 8'd0, 1'b0, 10'd0);
    send_item(ACT_ADD, 8'd97, 1'b1, 10'd0);
    send_item(ACT_NEXT, 8'd97, 1'b0, 10'd0);
    send_item(ACT_NEXT, 8'd20, 1'b0, 10'd0);
    send_item(ACT_NEXT, 8'd122, 1'b1, 10'd1023);
    send_item(ACT_INSPECT, 8'd0, 1'b0, 10'd1023);

    for (int n = 0; n < 120; n++) begin
      case ($urandom_range(0, 19))
        0:       send_item(ACT_ADD, 8'($urandom), 1'($urandom), 10'($urandom));
        1:       send_item(ACT_BUILD, 8'($urandom), 1'($urandom), 10'($urandom));
        2, 3, 4: send_item(ACT_INSPECT, 8'($urandom), 1'($urandom),
                           10'($urandom_range(0, sb.nodes_used + 3)));
        default: send_item(ACT_NEXT, pick_symbol(ALPH), 1'($urandom),
                           10'($urandom_range(0, sb.nodes_used + 3)));
      endcase
    end

    // Hold off until everything is back, move base, then run with no idling.
    write_base(8'd65);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < 120; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(ACT_INSPECT, 8'($urandom), 1'($urandom), 10'($urandom));
      else
        send_item(ACT_NEXT, pick_symbol(ALPH), 1'($urandom),
                  10'($urandom_range(0, sb.nodes_used + 3)));
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("** multi_pattern_match_automaton_unit: PASSED **");
    end else begin
      $display("** multi_pattern_match_automaton_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
